/* hw/rtl/dpba_pkg.sv */
// Shared types, codes and default sizes for the dual pool buffer allocator.
package dpba_pkg;

   localparam int SMALL_COUNT_DEFAULT = 16;
   localparam int BIG_COUNT_DEFAULT = 16;

   localparam int SIZE_W = 16;
   localparam int HANDLE_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SIZE_W-1:0] SMALL_LIMIT_RESET = 16'd128;
   localparam logic [SIZE_W-1:0] BIG_LIMIT_RESET = 16'd1536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMALL_LIMIT = 1'b0,
      CSR_BIG_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic {
      POOL_SMALL = 1'b0,
      POOL_BIG = 1'b1
   } pool_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_NO_RESOURCE = 2'd1,
      STATUS_TOO_BIG = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic pop;
      logic push;
   } pool_cmd_type;

   typedef struct packed {
      logic empty;
      logic can_push;
   } pool_stat_type;

endpackage

/* hw/rtl/dual_pool_buffer_allocator.sv */
// Top level of the dual pool buffer allocator: request decode, limits and response.
//
// For each transaction, start is sampled when busy is low, busy is high for
// the following cycle while the chosen pool's free stack RAM is read (alloc)
// or written (release), and the response is driven with rsp_strobe high for
// one cycle after that, during which a new transaction may already be started.
// The receiver cannot stall responses. The free stacks need no clearing pass
// after reset; a fill watermark per pool stands in for their initial contents.
module dual_pool_buffer_allocator #(
   parameter int SMALL_COUNT = dpba_pkg::SMALL_COUNT_DEFAULT,
   parameter int BIG_COUNT = dpba_pkg::BIG_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic [dpba_pkg::SIZE_W-1:0]      req_request_size,
   input  logic                             req_handle_pool,
   input  logic [dpba_pkg::HANDLE_W-1:0]    req_handle_index,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_granted_pool,
   output logic [dpba_pkg::HANDLE_W-1:0]    rsp_granted_index,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dpba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dpba_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SIW = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
   localparam int BIW = (BIG_COUNT > 1) ? $clog2(BIG_COUNT) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                         state_ff;
   state_type                         state_in;
   logic [dpba_pkg::SIZE_W-1:0]       small_limit_ff;
   logic [dpba_pkg::SIZE_W-1:0]       big_limit_ff;
   dpba_pkg::status_type              status_ff;
   dpba_pkg::status_type              status_in;
   dpba_pkg::pool_type                pool_ff;
   dpba_pkg::pool_type                pool_in;
   logic                              pop_ff;
   logic                              pop_in;
   logic                              rsp_strobe_ff;
   logic                              rsp_strobe_in;
   dpba_pkg::status_type              rsp_status_ff;
   dpba_pkg::status_type              rsp_status_in;
   logic                              rsp_pool_ff;
   logic                              rsp_pool_in;
   logic [dpba_pkg::HANDLE_W-1:0]     rsp_index_ff;
   logic [dpba_pkg::HANDLE_W-1:0]     rsp_index_in;
   logic                              accept;
   logic                              small_fit;
   logic                              big_fit;
   dpba_pkg::pool_cmd_type            small_cmd;
   dpba_pkg::pool_cmd_type            big_cmd;
   dpba_pkg::pool_stat_type           small_stat;
   dpba_pkg::pool_stat_type           big_stat;
   logic [SIW-1:0]                    small_pop_index;
   logic [BIW-1:0]                    big_pop_index;

   assign busy = (state_ff == ST_EXEC);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_pool = rsp_pool_ff;
   assign rsp_granted_index = rsp_index_ff;

   dpba_pool #(
      .COUNT (SMALL_COUNT),
      .IW    (SIW)
   ) u_small_pool (
      .clock        (clock),
      .reset        (reset),
      .cmd          (small_cmd),
      .handle_index (req_handle_index),
      .stat         (small_stat),
      .pop_index    (small_pop_index)
   );

   dpba_pool #(
      .COUNT (BIG_COUNT),
      .IW    (BIW)
   ) u_big_pool (
      .clock        (clock),
      .reset        (reset),
      .cmd          (big_cmd),
      .handle_index (req_handle_index),
      .stat         (big_stat),
      .pop_index    (big_pop_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff <= dpba_pkg::SMALL_LIMIT_RESET;
         big_limit_ff <= dpba_pkg::BIG_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dpba_pkg::CSR_SMALL_LIMIT: small_limit_ff <= csr_wdata;
            dpba_pkg::CSR_BIG_LIMIT: big_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      small_fit = req_request_size <= small_limit_ff;
      big_fit = req_request_size <= big_limit_ff;
      small_cmd = '0;
      big_cmd = '0;
      status_in = status_ff;
      pool_in = pool_ff;
      pop_in = pop_ff;
      if (accept) begin
         status_in = dpba_pkg::STATUS_OK;
         pool_in = dpba_pkg::POOL_SMALL;
         pop_in = 1'b0;
         if (req_kind == dpba_pkg::KIND_ALLOC) begin
            if (small_fit && !small_stat.empty) begin
               small_cmd.pop = 1'b1;
               pop_in = 1'b1;
            end else if ((small_fit || big_fit) && !big_stat.empty) begin
               big_cmd.pop = 1'b1;
               pool_in = dpba_pkg::POOL_BIG;
               pop_in = 1'b1;
            end else if (small_fit || big_fit) begin
               status_in = dpba_pkg::STATUS_NO_RESOURCE;
            end else begin
               status_in = dpba_pkg::STATUS_TOO_BIG;
            end
         end else begin
            if (small_fit && req_handle_pool == dpba_pkg::POOL_SMALL
                  && small_stat.can_push) begin
               small_cmd.push = 1'b1;
            end else if ((small_fit || big_fit)
                  && req_handle_pool == dpba_pkg::POOL_BIG && big_stat.can_push) begin
               big_cmd.push = 1'b1;
            end else if (small_fit || big_fit) begin
               status_in = dpba_pkg::STATUS_NOT_FOUND;
            end else begin
               status_in = dpba_pkg::STATUS_TOO_BIG;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pool_in = rsp_pool_ff;
      rsp_index_in = rsp_index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_pool_in = pop_ff && (pool_ff == dpba_pkg::POOL_BIG);
            if (!pop_ff) begin
               rsp_index_in = '0;
            end else if (pool_ff == dpba_pkg::POOL_BIG) begin
               rsp_index_in = dpba_pkg::HANDLE_W'(big_pop_index);
            end else begin
               rsp_index_in = dpba_pkg::HANDLE_W'(small_pop_index);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      status_ff <= status_in;
      pool_ff <= pool_in;
      pop_ff <= pop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pool_ff <= rsp_pool_in;
      rsp_index_ff <= rsp_index_in;
   end

   a_exec_then_response: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("transaction did not produce a response");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_strobe)
      else $error("accepted transaction did not enter execution");

   a_failed_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != dpba_pkg::STATUS_OK
      |-> !rsp_granted_pool && rsp_granted_index == '0)
      else $error("failed transaction reports a granted buffer");

   a_single_pool_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({small_cmd.pop, small_cmd.push, big_cmd.pop, big_cmd.push}) <= 1
      && (accept || (small_cmd == '0 && big_cmd == '0)))
      else $error("more than one pool operation per transaction");

endmodule

/* hw/rtl/dpba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dpba_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dpba_pool.sv */
// One buffer pool: free stack in RAM, free count, fill watermark and in-use marks.
module dpba_pool #(
   parameter int COUNT = dpba_pkg::SMALL_COUNT_DEFAULT,
   parameter int IW = (COUNT > 1) ? $clog2(COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dpba_pkg::pool_cmd_type        cmd,
   input  logic [dpba_pkg::HANDLE_W-1:0] handle_index,
   output dpba_pkg::pool_stat_type       stat,
   output logic [IW-1:0]                 pop_index
);

   localparam int CW = $clog2(COUNT + 1);

   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [CW-1:0]    low_ff;
   logic [CW-1:0]    low_in;
   logic [COUNT-1:0] mark_ff;
   logic [COUNT-1:0] mark_in;
   logic             pop_pend_ff;
   logic             push_pend_ff;
   logic [IW-1:0]    push_idx_ff;
   logic [IW-1:0]    handle_idx;
   logic             handle_in_range;
   logic             handle_hit;
   logic [IW-1:0]    ram_q;
   logic [IW-1:0]    rd_addr;
   logic [IW-1:0]    wr_addr;

   assign handle_idx = IW'(handle_index);
   assign handle_in_range = 32'(handle_index) < COUNT;
   assign handle_hit = handle_in_range && mark_ff[handle_idx];

   assign stat.empty = (count_ff == '0);
   assign stat.can_push = handle_hit && (count_ff < CW'(COUNT));

   assign rd_addr = IW'(count_ff - CW'(1));
   assign wr_addr = IW'(count_ff);

   // Stack slots below the watermark were never written since reset.
   assign pop_index = (count_ff <= low_ff) ? IW'(CW'(COUNT) - count_ff) : ram_q;

   dpba_ram #(
      .WIDTH (IW),
      .DEPTH (COUNT),
      .AW    (IW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push_pend_ff),
      .wr_addr (wr_addr),
      .wr_data (push_idx_ff),
      .rd_en   (cmd.pop),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      count_in = count_ff;
      low_in = low_ff;
      mark_in = mark_ff;
      if (pop_pend_ff) begin
         count_in = count_ff - CW'(1);
         mark_in[pop_index] = 1'b1;
         if (count_in < low_ff) begin
            low_in = count_in;
         end
      end else if (push_pend_ff) begin
         count_in = count_ff + CW'(1);
         mark_in[push_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(COUNT);
         low_ff <= CW'(COUNT);
         mark_ff <= '0;
         pop_pend_ff <= 1'b0;
         push_pend_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         low_ff <= low_in;
         mark_ff <= mark_in;
         pop_pend_ff <= cmd.pop;
         push_pend_ff <= cmd.push;
      end
      if (cmd.push) begin
         push_idx_ff <= handle_idx;
      end
   end

   a_count_matches_marks: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) + $countones(mark_ff) == COUNT)
      else $error("free count and in-use marks disagree");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop_pend_ff |-> count_ff != '0)
      else $error("pop from an empty free stack");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_pend_ff |-> count_ff < CW'(COUNT) && mark_ff[push_idx_ff])
      else $error("push onto a full stack or of a free buffer");

endmodule
